// File: design/lzw_pkg.sv
// Package for the LZW byte compressor: sizes and state encoding.
// No dependencies.
package lzw_pkg;
  localparam int CodeBitsDef = 12;
  localparam int HashEntriesDef = 5021;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOOKUP,
    ST_CHECK,
    ST_EMIT,
    ST_DRAIN
  } lzw_state_t;
endpackage

// File: design/lzw_byte_compressor_unit.sv
// Top level of the LZW byte compressor: hash dictionary memory and probe control.
// Depends on lzw_pkg and lzw_packer.
//
// Usage: raw bytes enter on in_valid/in_ready with in_is_first and in_is_last;
// packed 12-bit codes leave MSB first as bytes on out_valid/out_ready, with
// out_end_of_run set on the last byte a beat of input produced.
// Flow: one item at a time. A first byte is accepted, then the memory gets a
// clearing pass. A later byte is accepted, hashed and probed; each probe is a
// registered read, then a compare. A hit ends the item, a miss hands its code
// to the packer, and each collision adds another probe.
// The packer puts out one byte per cycle while the receiver is ready; a last
// byte adds three codes, 4 to 6 bytes, and each code waits until fewer than 8
// bits are held.
// in_ready is also held low until the packer holds fewer than 8 bits.
// Reset clears the control state and starts a clearing pass over the memory
// with in_ready low; the first beat with in_is_first clears the
// dictionary again. When the receiver stalls, the packer holds its byte and
// the code stream backs up, and in_ready stays low until the item is done.
module lzw_byte_compressor_unit #(
  parameter int CodeBits    = lzw_pkg::CodeBitsDef,
  parameter int HashEntries = lzw_pkg::HashEntriesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_in_byte,
  input  logic       in_is_first,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_end_of_run
);
  import lzw_pkg::*;
  localparam int AW = $clog2(HashEntries);
  localparam int EW = CodeBits + CodeBits + 8 + 1;
  localparam logic [CodeBits-1:0] EndCode = '1;
  localparam logic [CodeBits-1:0] LastFree = EndCode - 1'b1;
  localparam logic [CodeBits-1:0] FirstFree = CodeBits'(256);
  localparam logic [AW:0] HashN = (AW+1)'(HashEntries);

  // Entry: valid, code, prefix, suffix. Valid is cleared by a sweep at reset and at each in_is_first beat.
  logic [EW-1:0] mem [HashEntries];
  logic [EW-1:0] rd_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  lzw_state_t    st_r, st_nxt;
  logic [CodeBits-1:0] cur_r, cur_nxt, nfc_r, nfc_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] idx_r, idx_nxt, off_r, off_nxt;
  logic [AW:0]   tries_r, tries_nxt;
  logic [1:0]    emit_r, emit_nxt;
  logic          pend_r, pend_nxt;

  logic [CodeBits-1:0] code;
  logic code_valid, code_last, code_ready, clr;
  logic [AW:0] hv, red;
  logic ev;
  logic [CodeBits-1:0] ecode, epre;
  logic [7:0] esuf;

  lzw_packer #(.CodeBits(CodeBits)) u_pack (
    .clk, .rst_n, .clr, .code_valid, .code, .code_last, .code_ready,
    .out_valid, .out_ready, .out_byte(out_out_byte), .end_of_run(out_end_of_run)
  );

  assign {ev, ecode, epre, esuf} = rd_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[idx_r];
  end

  always_comb begin
    st_nxt = st_r; cur_nxt = cur_r; nfc_nxt = nfc_r; byte_nxt = byte_r;
    last_nxt = last_r; idx_nxt = idx_r; off_nxt = off_r; tries_nxt = tries_r;
    emit_nxt = emit_r; pend_nxt = pend_r;
    in_ready = 1'b0; we = 1'b0; wa = idx_r; wd = '0; clr = 1'b0;
    code_valid = 1'b0; code = cur_r; code_last = 1'b0;
    // Hash of the byte and current prefix, reduced by compare-subtract steps.
    hv  = (AW+1)'({byte_r, (CodeBits-8)'(0)} ^ cur_r);
    red = hv;
    while_red: begin
      if (red >= HashN) red = red - HashN;
      if (red >= HashN) red = red - HashN;
      if (red >= HashN) red = red - HashN;
    end
    case (st_r)
      ST_IDLE: begin
        // Wait until the packer holds no whole byte, so a clear loses nothing.
        in_ready = code_ready;
        if (in_valid && code_ready) begin
          byte_nxt = in_in_byte;
          last_nxt = in_is_last;
          if (in_is_first) begin
            clr = 1'b1;
            cur_nxt = CodeBits'(in_in_byte);
            nfc_nxt = FirstFree;
            idx_nxt = '0;
            st_nxt = ST_CLEAR;
          end else begin
            st_nxt = ST_LOOKUP;
          end
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        if (idx_r == AW'(HashEntries - 1)) begin
          idx_nxt = '0;
          emit_nxt = 2'd0;
          st_nxt = last_r ? ST_DRAIN : ST_IDLE;
        end else idx_nxt = idx_r + 1'b1;
      end
      ST_LOOKUP: begin
        idx_nxt = red[AW-1:0];
        off_nxt = (red == '0) ? AW'(1) : AW'(HashN - red);
        tries_nxt = '0;
        pend_nxt = 1'b1;
        st_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!ev || (epre == cur_r && esuf == byte_r) || tries_r == HashN) begin
          if (ev && epre == cur_r && esuf == byte_r && tries_r != HashN) begin
            cur_nxt = ecode;
            emit_nxt = 2'd0;
            st_nxt = last_r ? ST_DRAIN : ST_IDLE;
          end else begin
            if (!ev && tries_r != HashN && nfc_r <= LastFree) begin
              we = 1'b1;
              wd = {1'b1, nfc_r, cur_r, byte_r};
              nfc_nxt = nfc_r + 1'b1;
            end
            st_nxt = ST_EMIT;
          end
        end else begin
          idx_nxt = (idx_r >= off_r) ? idx_r - off_r
                  : AW'((AW+1)'(idx_r) + HashN - (AW+1)'(off_r));
          tries_nxt = tries_r + 1'b1;
          st_nxt = ST_CHECK;
        end
        if (st_nxt == ST_CHECK) pend_nxt = 1'b1;
        if (pend_r) begin
          // Read data for the new address arrives next cycle.
          st_nxt = ST_CHECK; we = 1'b0; cur_nxt = cur_r; nfc_nxt = nfc_r;
          idx_nxt = idx_r; tries_nxt = tries_r; pend_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        code_valid = 1'b1;
        code_last = !last_r;
        if (code_ready) begin
          cur_nxt = CodeBits'(byte_r);
          emit_nxt = 2'd0;
          st_nxt = last_r ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        code_valid = 1'b1;
        case (emit_r)
          2'd0: code = cur_r;
          2'd1: code = EndCode;
          default: code = '0;
        endcase
        code_last = (emit_r == 2'd2);
        if (code_ready) begin
          emit_nxt = emit_r + 1'b1;
          if (emit_r == 2'd2) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; cur_r <= '0; nfc_r <= FirstFree; idx_r <= '0;
      emit_r <= '0; pend_r <= 1'b0; last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cur_r <= cur_nxt; nfc_r <= nfc_nxt; idx_r <= idx_nxt;
      emit_r <= emit_nxt; pend_r <= pend_nxt; last_r <= last_nxt;
    end
    byte_r <= byte_nxt; off_r <= off_nxt; tries_r <= tries_nxt;
  end
endmodule

// File: design/lzw_packer.sv
// Bit packer: takes codes and hands out bytes MSB first with an output register.
// Depends on lzw_pkg.
module lzw_packer #(
  parameter int CodeBits = lzw_pkg::CodeBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  logic                code_valid,
  input  logic [CodeBits-1:0] code,
  input  logic                code_last,
  output logic                code_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                end_of_run
);
  import lzw_pkg::*;
  localparam int PW = CodeBits + 8;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] bits_r, bits_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          last_r, last_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          oe_r, oe_nxt;
  logic          slot_free;
  logic [PW-1:0] ins;

  assign slot_free  = !ov_r || out_ready;
  assign code_ready = (cnt_r < CW'(8));
  assign out_valid  = ov_r;
  assign out_byte   = ob_r;
  assign end_of_run = oe_r;

  always_comb begin
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    ov_nxt   = ov_r && !out_ready;
    ob_nxt   = ob_r;
    oe_nxt   = oe_r;
    ins      = PW'(code) << (PW - CodeBits);
    if (clr) begin
      bits_nxt = '0;
      cnt_nxt  = '0;
      last_nxt = 1'b0;
    end else if (cnt_r >= CW'(8)) begin
      if (slot_free) begin
        ov_nxt   = 1'b1;
        ob_nxt   = bits_r[PW-1 -: 8];
        bits_nxt = bits_r << 8;
        cnt_nxt  = cnt_r - CW'(8);
        oe_nxt   = last_r && (cnt_r - CW'(8) < CW'(8));
        if (oe_nxt) last_nxt = 1'b0;
      end
    end else if (code_valid) begin
      bits_nxt = bits_r | (ins >> cnt_r);
      cnt_nxt  = cnt_r + CW'(CodeBits);
      last_nxt = code_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      cnt_r  <= '0;
      last_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      ov_r   <= ov_nxt;
    end
    ob_r <= ob_nxt;
    oe_r <= oe_nxt;
  end
endmodule

// File: tb/tb.sv
// Self-checking testbench for lzw_byte_compressor_unit: drives byte streams and
// checks each packed output byte against an LZW model or a row's fixed bytes.
// Depends on lzw_pkg and the RTL of the compressor.
module tb;
  import lzw_pkg::*;

  localparam int CodeBits    = CodeBitsDef;
  localparam int HashEntries = HashEntriesDef;
  localparam logic [11:0] EndCode       = 12'hFFF;
  localparam int          LastFreeCode  = 4094;
  localparam int          FirstFreeCode = 256;
  localparam int          CycleLimit    = 3000000;
  localparam int          MaxReport     = 10;

  typedef struct {
    logic [7:0] data;
    logic       eor;
  } packed_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    int         n_ref;
    logic [7:0] ref_bytes [6];
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_in_byte = 8'h00;
  logic       in_is_first = 1'b0;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_end_of_run;

  lzw_byte_compressor_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_in_byte    (in_in_byte),
    .in_is_first   (in_is_first),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_end_of_run(out_end_of_run)
  );

  always #1 clk = ~clk;

  // Dictionary and packer state of the model.
  bit          dict_valid  [HashEntries];
  logic [11:0] dict_code   [HashEntries];
  logic [11:0] dict_prefix [HashEntries];
  logic [7:0]  dict_suffix [HashEntries];
  logic [11:0] cur_string;
  int          free_code;
  logic [31:0] bit_acc;
  int          bit_cnt;

  packed_beat_t packed_bytes_q[$];
  packed_beat_t item_bytes[$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  sender_idle = 0;
  int  recv_stall = 0;
  bit  use_ref = 1'b0;
  stim_row_t cur_row;

  function automatic void clear_dictionary();
    foreach (dict_valid[i]) dict_valid[i] = 1'b0;
    cur_string = '0;
    free_code  = FirstFreeCode;
    bit_acc    = '0;
    bit_cnt    = 0;
  endfunction

  function automatic void pack_code(logic [11:0] code);
    bit_acc = bit_acc | ({20'd0, code} << (32 - CodeBits - bit_cnt));
    bit_cnt += CodeBits;
    while (bit_cnt >= 8) begin
      item_bytes.push_back('{data: bit_acc[31:24], eor: 1'b0});
      bit_acc = bit_acc << 8;
      bit_cnt -= 8;
    end
  endfunction

  // Computes the packed bytes one accepted input byte produces.
  function automatic void compress_byte(logic [7:0] b, logic first, logic last);
    int idx;
    int off;
    bit hit;
    bit found;
    item_bytes.delete();
    if (first) begin
      clear_dictionary();
      cur_string = {4'd0, b};
    end else begin
      idx = int'(({4'd0, b} << (CodeBits - 8)) ^ cur_string) % HashEntries;
      off = (idx == 0) ? 1 : HashEntries - idx;
      hit = 1'b0;
      found = 1'b0;
      for (int t = 0; t < HashEntries; t++) begin
        if (!dict_valid[idx]) begin
          found = 1'b1;
          break;
        end
        if (dict_prefix[idx] == cur_string && dict_suffix[idx] == b) begin
          hit = 1'b1;
          found = 1'b1;
          break;
        end
        idx = (idx >= off) ? idx - off : idx + HashEntries - off;
      end
      if (hit) begin
        cur_string = dict_code[idx];
      end else begin
        if (found && free_code <= LastFreeCode) begin
          dict_valid[idx]  = 1'b1;
          dict_code[idx]   = free_code[11:0];
          dict_prefix[idx] = cur_string;
          dict_suffix[idx] = b;
          free_code++;
        end
        pack_code(cur_string);
        cur_string = {4'd0, b};
      end
    end
    if (last) begin
      pack_code(cur_string);
      pack_code(EndCode);
      pack_code(12'd0);
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].eor = 1'b1;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall);
    if (out_valid && out_ready) begin
      if (packed_bytes_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReport)
          $display("unexpected output beat: byte %h eor %b", out_out_byte, out_end_of_run);
      end else begin
        packed_beat_t e;
        e = packed_bytes_q.pop_front();
        if (e.data !== out_out_byte || e.eor !== out_end_of_run) begin
          err_cnt++;
          if (err_cnt <= MaxReport)
            $display("mismatch: expected byte %h eor %b, got byte %h eor %b",
                     e.data, e.eor, out_out_byte, out_end_of_run);
        end
      end
    end
    if (in_valid && in_ready) begin
      compress_byte(in_in_byte, in_is_first, in_is_last);
      if (use_ref) begin
        for (int i = 0; i < cur_row.n_ref; i++)
          packed_bytes_q.push_back('{data: cur_row.ref_bytes[i],
                                     eor: (i == cur_row.n_ref - 1)});
      end else begin
        foreach (item_bytes[i]) packed_bytes_q.push_back(item_bytes[i]);
      end
    end
  end

  // Called right after an acceptance edge, or once after reset.
  task automatic send_byte(logic [7:0] b, logic first, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_in_byte  <= b;
    in_is_first <= first;
    in_is_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_stream(int len, bit narrow, bit no_first, bit no_last);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = narrow ? 8'($urandom_range(3)) : 8'($urandom);
      send_byte(b, (i == 0) && !no_first, (i == len - 1) && !no_last);
    end
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t mk(logic [7:0] b, logic f, logic l);
    stim_row_t r;
    r.data = b;
    r.first = f;
    r.last = l;
    r.n_ref = 0;
    foreach (r.ref_bytes[i]) r.ref_bytes[i] = 8'h00;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    int idle_tab [4] = '{0, 78, 0, 31};
    int stall_tab[4] = '{0, 0, 78, 31};
    clear_dictionary();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Without a first mark the stream runs on from the reset state.
    r = mk(8'hFF, 1'b0, 1'b1);
    r.n_ref = 6;
    r.ref_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h00};
    rows.push_back(r);
    // A one-byte stream leaves four bits behind in the packer.
    r = mk(8'h41, 1'b1, 1'b1);
    r.n_ref = 4;
    r.ref_bytes = '{8'h04, 8'h1F, 8'hFF, 8'h00, 8'h00, 8'h00};
    rows.push_back(r);
    // The leftover bits carry into a stream that lacks a first mark.
    rows.push_back(mk(8'h00, 1'b0, 1'b0));
    rows.push_back(mk(8'h00, 1'b0, 1'b1));
    rows.push_back(mk(8'h00, 1'b1, 1'b0));
    for (int i = 0; i < 8; i++) rows.push_back(mk(8'h00, 1'b0, 1'b0));
    rows.push_back(mk(8'hFF, 1'b0, 1'b0));
    rows.push_back(mk(8'hFF, 1'b0, 1'b0));
    rows.push_back(mk(8'h00, 1'b0, 1'b0));
    rows.push_back(mk(8'hFF, 1'b0, 1'b0));
    rows.push_back(mk(8'hAA, 1'b0, 1'b0));
    rows.push_back(mk(8'h55, 1'b0, 1'b1));
    rows.push_back(mk(8'h00, 1'b1, 1'b1));
    rows.push_back(mk(8'hFF, 1'b1, 1'b1));

    foreach (rows[i]) begin
      cur_row <= rows[i];
      use_ref <= (rows[i].n_ref > 0);
      send_byte(rows[i].data, rows[i].first, rows[i].last);
    end
    use_ref <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      sender_idle = idle_tab[p];
      recv_stall = stall_tab[p];
      for (int s = 0; s < 6; s++) begin
        int kind;
        kind = $urandom_range(9);
        send_stream($urandom_range(30, 5), ($urandom_range(2) != 0),
                    (kind == 0), (kind == 1));
      end
      send_stream(1, 1'b0, 1'b0, 1'b0);
    end

    // A short stream over a narrow alphabet closes the run.
    sender_idle = 0;
    recv_stall = 0;
    send_stream(20, 1'b1, 1'b0, 1'b0);
    in_valid <= 1'b0;

    while (packed_bytes_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/lzw_pkg.sv
design/lzw_packer.sv
design/lzw_byte_compressor_unit.sv
tb/tb.sv
